// File: design/aes_pkg.sv
// Package for the AES-256 counter-mode keystream block.
// Holds payload structs, the S-box, round helpers and shared constants; no dependencies.
package aes_pkg;

	localparam int MaxGroups = 16;
	localparam int NumCfg = 5;
	localparam int NumRk = 15;

	typedef enum logic [2:0] {
		CFG_KEY0  = 3'd0,
		CFG_KEY1  = 3'd1,
		CFG_KEY2  = 3'd2,
		CFG_KEY3  = 3'd3,
		CFG_NONCE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic       restart;
		logic [4:0] block_count;
	} req_t;

	typedef struct packed {
		logic [63:0] keystream_low;
		logic [63:0] keystream_high;
		logic        last;
	} rsp_t;

	// Command passed from the front end to the cipher engine.
	typedef struct packed {
		logic       restart;
		logic [6:0] blocks;
	} cmd_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_EXPAND,
		ENG_RUN
	} eng_state_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// State is 16 bytes, byte i at bits [8*i+7:8*i] (little-endian).
	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
			input logic final_round);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			for (int row = 0; row < 4; row++) begin
				t[8*(row+4*c) +: 8] = sbox(s[8*(row + 4*((c + row) % 4)) +: 8]);
			end
		end
		if (!final_round) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[32*c +: 8];
				a1 = t[32*c+8 +: 8];
				a2 = t[32*c+16 +: 8];
				a3 = t[32*c+24 +: 8];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
				t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
				t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
				t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		return t ^ k;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// File: design/aes_front.sv
// Front end: accepts requests, saturates the group count and queues commands.
// Depends on aes_pkg; feeds aes_engine through a two-entry queue.
module aes_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  aes_pkg::req_t in_data,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output aes_pkg::cmd_t cmd_data
);

	aes_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          push, pop;
	logic [4:0]    groups;
	aes_pkg::cmd_t cmd_new;

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd_data  = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		groups = (in_data.block_count > 5'(aes_pkg::MaxGroups)) ?
			5'(aes_pkg::MaxGroups) : in_data.block_count;
		cmd_new.restart = in_data.restart;
		cmd_new.blocks  = {groups, 2'b00};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: design/aes_engine.sv
// Back end: key expansion and an iterative AES-256 round unit, one round per cycle.
// Depends on aes_pkg; takes commands from aes_front, drives an output register.
module aes_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [255:0]  key,
	input  logic [63:0]   nonce,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  aes_pkg::cmd_t cmd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output aes_pkg::rsp_t out_data
);

	aes_pkg::eng_state_t state_q, state_d;
	logic [127:0] rk_q [aes_pkg::NumRk];
	logic [255:0] kexp_q;
	logic [7:0]   rcon_q;
	logic [2:0]   kstep_q;
	logic         keys_ready_q;
	logic [63:0]  ctr_q;
	logic [6:0]   left_q;
	logic [127:0] st_q;
	logic [3:0]   round_q;
	logic         busy_q;
	logic         rsp_valid_q;
	aes_pkg::rsp_t rsp_q;
	logic         take_cmd, need_expand, exp_done, blk_done, can_finish, start_blk;
	logic [127:0] cblk, rnd_out;
	logic [31:0]  w0, w1, w2, w3, w4, w5, w6, w7, t0;

	assign need_expand = cmd_data.restart || !keys_ready_q;
	assign exp_done    = (state_q == aes_pkg::ENG_EXPAND) && (kstep_q == 3'd6);
	assign blk_done    = busy_q && (round_q == 4'd13);
	assign can_finish  = !rsp_valid_q || out_ready;
	assign out_valid   = rsp_valid_q;
	assign out_data    = rsp_q;

	always_comb begin
		state_d   = state_q;
		take_cmd  = 1'b0;
		case (state_q)
			aes_pkg::ENG_IDLE: begin
				if (cmd_valid) begin
					take_cmd = 1'b1;
					state_d  = need_expand ? aes_pkg::ENG_EXPAND :
						(cmd_data.blocks != 7'd0 ? aes_pkg::ENG_RUN : aes_pkg::ENG_IDLE);
				end
			end
			aes_pkg::ENG_EXPAND: begin
				if (exp_done) state_d = (left_q != 7'd0) ? aes_pkg::ENG_RUN : aes_pkg::ENG_IDLE;
			end
			aes_pkg::ENG_RUN: begin
				if (left_q == 7'd0 && !busy_q) state_d = aes_pkg::ENG_IDLE;
			end
			default: state_d = aes_pkg::ENG_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = take_cmd;
		start_blk = (state_q == aes_pkg::ENG_RUN) && !busy_q && (left_q != 7'd0);
		cblk      = {ctr_q, nonce};
		rnd_out   = aes_pkg::enc_round(st_q, rk_q[round_q + 4'd1], round_q == 4'd13);
		w0 = kexp_q[31:0];    w1 = kexp_q[63:32];   w2 = kexp_q[95:64];
		w3 = kexp_q[127:96];  w4 = kexp_q[159:128]; w5 = kexp_q[191:160];
		w6 = kexp_q[223:192]; w7 = kexp_q[255:224];
		t0 = aes_pkg::sub_word({w7[7:0], w7[31:8]}) ^ {24'd0, rcon_q};
		t0 = {t0[31:0]};
	end

	// Eight new words per step: w0'..w3' use RotWord/Rcon, w4'..w7' use SubWord.
	logic [31:0] n0, n1, n2, n3, n4, n5, n6, n7;
	always_comb begin
		n0 = w0 ^ t0;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		n4 = w4 ^ aes_pkg::sub_word(n3);
		n5 = w5 ^ n4;
		n6 = w6 ^ n5;
		n7 = w7 ^ n6;
	end

	always_ff @(posedge clk) begin
		if (state_q == aes_pkg::ENG_IDLE && take_cmd && need_expand) begin
			kexp_q   <= key;
			rk_q[0]  <= key[127:0];
			rk_q[1]  <= key[255:128];
		end else if (state_q == aes_pkg::ENG_EXPAND) begin
			kexp_q <= {n7, n6, n5, n4, n3, n2, n1, n0};
			rk_q[{kstep_q, 1'b0} + 4'd2] <= {n3, n2, n1, n0};
			if (kstep_q != 3'd6) rk_q[{kstep_q, 1'b0} + 4'd3] <= {n7, n6, n5, n4};
		end
		// The state holds still after the last round while the result waits.
		if (start_blk) begin
			st_q <= cblk ^ rk_q[0];
		end else if (busy_q && !blk_done) begin
			st_q <= rnd_out;
		end
		if (blk_done && can_finish) begin
			rsp_q.keystream_low  <= rnd_out[63:0];
			rsp_q.keystream_high <= rnd_out[127:64];
			rsp_q.last           <= (left_q == 7'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= aes_pkg::ENG_IDLE;
			rcon_q       <= 8'h01;
			kstep_q      <= 3'd0;
			keys_ready_q <= 1'b0;
			ctr_q        <= 64'd0;
			left_q       <= 7'd0;
			round_q      <= 4'd0;
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_cmd) begin
				left_q <= cmd_data.blocks;
				if (need_expand) begin
					ctr_q        <= 64'd0;
					keys_ready_q <= 1'b1;
					rcon_q       <= 8'h01;
					kstep_q      <= 3'd0;
				end
			end
			if (state_q == aes_pkg::ENG_EXPAND) begin
				rcon_q  <= aes_pkg::xtime(rcon_q);
				kstep_q <= kstep_q + 3'd1;
			end
			if (start_blk) begin
				busy_q  <= 1'b1;
				round_q <= 4'd0;
				left_q  <= left_q - 7'd1;
				ctr_q   <= ctr_q + 64'd1;
			end else if (busy_q && round_q != 4'd13) begin
				round_q <= round_q + 4'd1;
			end else if (busy_q && can_finish) begin
				busy_q <= 1'b0;
			end
			if (busy_q && round_q == 4'd13 && can_finish) begin
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/aes256_ctr_keystream.sv
// Top level of the AES-256 counter-mode keystream block.
// Depends on aes_pkg, aes_front and aes_engine; holds the configuration registers.

// Each request yields 4*block_count 16-byte keystream blocks (block_count above
// 16 counts as 16). The shared round unit does one AES round per cycle; a block
// loads the counter block with the first round key and then takes fourteen
// rounds, four blocks to a 64-byte group, and waits while the output is stalled.
// A restart, or the first request after reset, first runs a key
// expansion from the key registers and clears the counter. A request queue
// between the front end and the cipher engine lets requests be taken while
// earlier ones are still being served; nonce writes apply to later blocks.
module aes256_ctr_keystream (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  aes_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output aes_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	logic [63:0]   cfg_q [aes_pkg::NumCfg];
	logic          cmd_valid, cmd_ready;
	aes_pkg::cmd_t cmd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aes_pkg::NumCfg; i++) cfg_q[i] <= 64'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				aes_pkg::CFG_KEY0:  cfg_q[0] <= cfg_data;
				aes_pkg::CFG_KEY1:  cfg_q[1] <= cfg_data;
				aes_pkg::CFG_KEY2:  cfg_q[2] <= cfg_data;
				aes_pkg::CFG_KEY3:  cfg_q[3] <= cfg_data;
				aes_pkg::CFG_NONCE: cfg_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	aes_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
	);

	aes_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.key({cfg_q[3], cfg_q[2], cfg_q[1], cfg_q[0]}), .nonce(cfg_q[4]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
